// ===== design/owsp_pkg.sv =====
// Shared types, sequence steps and helpers for the omni wheel speed controller.
package owsp_pkg;

  localparam int unsigned SpeedW = 24;
  localparam int unsigned CountW = 16;
  localparam int unsigned PowerW = 16;
  localparam int unsigned LimitW = 15;
  localparam int unsigned OpAW   = 34;
  localparam int unsigned OpBW   = 17;
  localparam int unsigned ProdW  = OpAW + OpBW;
  localparam int unsigned AccW   = 44;
  localparam int unsigned SumW   = 52;
  localparam int unsigned StepW  = 4;

  // Multiplier schedule of one lane
  localparam logic [StepW-1:0] StepNormSin  = 4'd0;
  localparam logic [StepW-1:0] StepTanCos   = 4'd1;
  localparam logic [StepW-1:0] StepAngRad   = 4'd2;
  localparam logic [StepW-1:0] StepMeasure  = 4'd3;
  localparam logic [StepW-1:0] StepError    = 4'd4;
  localparam logic [StepW-1:0] StepProp     = 4'd5;
  localparam logic [StepW-1:0] StepInteg    = 4'd6;
  localparam logic [StepW-1:0] StepDeriv    = 4'd7;
  localparam logic [StepW-1:0] StepCommit   = 4'd8;

  typedef struct packed {
    logic             en;
    logic [StepW-1:0] step;
  } lane_ctrl_t;

  function automatic logic signed [PowerW-1:0] clamp_sym(input logic signed [SumW-1:0] v,
                                                         input logic [LimitW-1:0] lim);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    logic signed [SumW-1:0] r;
    hi = $signed({{(SumW-LimitW){1'b0}}, lim});
    lo = -hi;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return r[PowerW-1:0];
  endfunction

endpackage

// ===== design/owsp_lane.sv =====
// One wheel lane: kinematics, speed measurement and PID over a shared multiplier.
module owsp_lane (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  owsp_pkg::lane_ctrl_t                     ctrl_i,
  input  logic signed [owsp_pkg::SpeedW-1:0]       tgt_tangent_i,
  input  logic signed [owsp_pkg::SpeedW-1:0]       tgt_normal_i,
  input  logic signed [owsp_pkg::SpeedW-1:0]       tgt_angular_i,
  input  logic [31:0]                              dir_i,
  input  logic [15:0]                              radius_i,
  input  logic [23:0]                              scale_i,
  input  logic [15:0]                              kp_i,
  input  logic [15:0]                              ki_i,
  input  logic [15:0]                              kd_i,
  input  logic [owsp_pkg::LimitW-1:0]              limit_i,
  input  logic [owsp_pkg::CountW-1:0]              count_i,
  output logic signed [owsp_pkg::PowerW-1:0]      power_o
);

  localparam int unsigned OpAW  = owsp_pkg::OpAW;
  localparam int unsigned OpBW  = owsp_pkg::OpBW;
  localparam int unsigned ProdW = owsp_pkg::ProdW;
  localparam int unsigned AccW  = owsp_pkg::AccW;
  localparam int unsigned SumW  = owsp_pkg::SumW;

  logic [owsp_pkg::CountW-1:0]   prev_count_q;
  logic signed [31:0]            prev_err_q;
  logic signed [15:0]            integ_q;
  logic signed [ProdW-1:0]       prod_q;
  logic signed [AccW-1:0]        acc_q;
  logic signed [AccW-1:0]        acc_d;
  logic signed [31:0]            err_q;
  logic signed [SumW-1:0]        p_q;

  logic signed [OpAW-1:0]        op_a;
  logic signed [OpBW-1:0]        op_b;
  logic signed [15:0]            delta;
  logic signed [AccW:0]          err_wide;
  logic signed [31:0]            err_sat;
  logic signed [ProdW-1:0]       prod_shr;
  logic signed [SumW-1:0]        integ_sum;
  logic signed [SumW-1:0]        pow_sum;

  assign delta = $signed(count_i - prev_count_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctrl_i.step)
      owsp_pkg::StepNormSin: begin
        op_a = OpAW'(tgt_normal_i);
        op_b = OpBW'($signed(dir_i[31:16]));
      end
      owsp_pkg::StepTanCos: begin
        op_a = OpAW'(tgt_tangent_i);
        op_b = OpBW'($signed(dir_i[15:0]));
      end
      owsp_pkg::StepAngRad: begin
        op_a = OpAW'(tgt_angular_i);
        op_b = $signed({1'b0, radius_i});
      end
      owsp_pkg::StepMeasure: begin
        op_a = $signed({{(OpAW-24){1'b0}}, scale_i});
        op_b = OpBW'(delta);
      end
      owsp_pkg::StepProp: begin
        op_a = OpAW'(err_q);
        op_b = $signed({1'b0, kp_i});
      end
      owsp_pkg::StepInteg: begin
        op_a = OpAW'(err_q);
        op_b = $signed({1'b0, ki_i});
      end
      owsp_pkg::StepDeriv: begin
        op_a = OpAW'(err_q) - OpAW'(prev_err_q);
        op_b = $signed({1'b0, kd_i});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    unique case (ctrl_i.step)
      owsp_pkg::StepTanCos:  acc_d = AccW'(prod_q) <<< 1;
      owsp_pkg::StepAngRad:  acc_d = acc_q + (AccW'(prod_q) <<< 1);
      owsp_pkg::StepMeasure: acc_d = acc_q + AccW'(prod_q);
      default:               acc_d = acc_q;
    endcase
  end

  // target minus measured, saturated to 32 bits
  always_comb begin
    err_wide = (AccW+1)'(acc_q >>> 16) - (AccW+1)'(prod_q);
    if (err_wide > (AccW+1)'(32'sh7FFF_FFFF)) err_sat = 32'sh7FFF_FFFF;
    else if (err_wide < -(AccW+1)'(33'sh0_8000_0000)) err_sat = 32'sh8000_0000;
    else err_sat = err_wide[31:0];
  end

  assign prod_shr  = prod_q >>> 9;
  assign integ_sum = SumW'(integ_q) + SumW'(prod_shr);
  assign pow_sum   = p_q + SumW'(integ_q) + SumW'(prod_shr);
  assign power_o   = owsp_pkg::clamp_sym(pow_sum, limit_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= op_a * op_b;
      acc_q  <= acc_d;
      if (ctrl_i.step == owsp_pkg::StepError) err_q <= err_sat;
      if (ctrl_i.step == owsp_pkg::StepInteg) p_q <= SumW'(prod_shr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      prev_err_q   <= '0;
      integ_q      <= '0;
    end else if (ctrl_i.en) begin
      if (ctrl_i.step == owsp_pkg::StepDeriv) integ_q <= owsp_pkg::clamp_sym(integ_sum, limit_i);
      if (ctrl_i.step == owsp_pkg::StepCommit) begin
        prev_count_q <= count_i;
        prev_err_q   <= err_q;
      end
    end
  end

endmodule

// ===== design/omni_wheel_speed_pid.sv =====
// Omni wheel speed controller: registers, item sequencing, lanes and result merge.
//
// Usage: one input transaction is one control tick. tuser carries new_command;
// when it is set the three body speeds in tdata are latched as the new target,
// otherwise they are ignored. tdata also carries one 16-bit encoder count per
// wheel. One output transaction per tick carries the clamped power of every
// wheel, wheel 0 in the lowest bits.
// Each wheel has its own lane with one shared 34x17 multiplier; a lane runs a
// fixed nine-step schedule (three kinematics products, one measurement
// product, error saturation, three PID products, commit). An item runs
// through all nine steps before the block accepts the next one.
// The input is ready whenever no item is in the lanes, even while a finished
// result waits on the output. If the receiver stalls, the next item stops at
// its commit step until the output register is free.
// Reset clears the command targets, the per-wheel history and the integral terms,
// and loads the default gains and power limit. Configuration goes through APB;
// the user makes writes only while the block is idle, which it does not enforce.
module omni_wheel_speed_pid #(
  parameter int unsigned NUM_WHEELS = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tangent[23:0], normal[47:24], angular[71:48], encoder_count_w from bit 72 up
  input  logic [72+16*NUM_WHEELS-1:0]           s_axis_tdata_i,
  // new_command
  input  logic                                  s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // motor_power_w at bits 16*w+15:16*w
  output logic [16*NUM_WHEELS-1:0]              m_axis_tdata_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [$clog2(8*(NUM_WHEELS+4))-1:0]   paddr,
  input  logic [63:0]                           pwdata,
  output logic [63:0]                           prdata,
  output logic                                  pready
);

  localparam int unsigned AddrW   = $clog2(8*(NUM_WHEELS+4));
  localparam int unsigned IdxW    = AddrW - 3;
  localparam int unsigned RegRad  = NUM_WHEELS;
  localparam int unsigned RegScl  = NUM_WHEELS + 1;
  localparam int unsigned RegGain = NUM_WHEELS + 2;
  localparam int unsigned RegLim  = NUM_WHEELS + 3;
  localparam logic [47:0] GainsReset = 48'd10995133054976;
  localparam logic [14:0] LimitReset = 15'd16384;

  logic [31:0] dir_q [NUM_WHEELS];
  logic [15:0] radius_q;
  logic [23:0] scale_q;
  logic [47:0] gains_q;
  logic [14:0] limit_q;

  logic signed [23:0] tgt_tangent_q;
  logic signed [23:0] tgt_normal_q;
  logic signed [23:0] tgt_angular_q;
  logic [15:0]        count_q [NUM_WHEELS];

  logic                          busy_q;
  logic [owsp_pkg::StepW-1:0]    step_q;
  logic                          out_valid_q;
  logic [16*NUM_WHEELS-1:0]      out_data_q;
  logic                          advance;
  logic                          accept;
  logic                          cfg_wr;
  logic [IdxW-1:0]               cfg_idx;
  owsp_pkg::lane_ctrl_t          lane_ctrl;
  logic signed [15:0]            power [NUM_WHEELS];
  logic [16*NUM_WHEELS-1:0]      merged;

  assign pready          = 1'b1;
  assign cfg_wr          = psel && penable && pwrite && pready;
  assign cfg_idx         = paddr[AddrW-1:3];
  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  // hold at commit while the previous result still waits
  assign advance = busy_q &&
                   !(step_q == owsp_pkg::StepCommit && out_valid_q && !m_axis_tready_i);
  assign lane_ctrl = '{en: advance, step: step_q};
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    prdata = '0;
    if (32'(cfg_idx) < NUM_WHEELS) prdata = {32'd0, dir_q[cfg_idx[$clog2(NUM_WHEELS)-1:0]]};
    else if (32'(cfg_idx) == RegRad) prdata = {48'd0, radius_q};
    else if (32'(cfg_idx) == RegScl) prdata = {40'd0, scale_q};
    else if (32'(cfg_idx) == RegGain) prdata = {16'd0, gains_q};
    else if (32'(cfg_idx) == RegLim) prdata = {49'd0, limit_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WHEELS; w++) dir_q[w] <= '0;
      radius_q <= '0;
      scale_q  <= '0;
      gains_q  <= GainsReset;
      limit_q  <= LimitReset;
    end else if (cfg_wr) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        if (32'(cfg_idx) == w) dir_q[w] <= pwdata[31:0];
      end
      if (32'(cfg_idx) == RegRad) radius_q <= pwdata[15:0];
      if (32'(cfg_idx) == RegScl) scale_q <= pwdata[23:0];
      if (32'(cfg_idx) == RegGain) gains_q <= pwdata[47:0];
      if (32'(cfg_idx) == RegLim) limit_q <= pwdata[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_tangent_q <= '0;
      tgt_normal_q  <= '0;
      tgt_angular_q <= '0;
    end else if (accept && s_axis_tuser_i) begin
      tgt_tangent_q <= $signed(s_axis_tdata_i[23:0]);
      tgt_normal_q  <= $signed(s_axis_tdata_i[47:24]);
      tgt_angular_q <= $signed(s_axis_tdata_i[71:48]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int w = 0; w < NUM_WHEELS; w++) count_q[w] <= s_axis_tdata_i[72+16*w +: 16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= owsp_pkg::StepNormSin;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      if (accept) begin
        busy_q <= 1'b1;
        step_q <= owsp_pkg::StepNormSin;
      end else if (advance) begin
        if (step_q == owsp_pkg::StepCommit) begin
          busy_q      <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_q == owsp_pkg::StepCommit) out_data_q <= merged;
  end

  for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_lane
    owsp_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (lane_ctrl),
      .tgt_tangent_i (tgt_tangent_q),
      .tgt_normal_i  (tgt_normal_q),
      .tgt_angular_i (tgt_angular_q),
      .dir_i         (dir_q[w]),
      .radius_i      (radius_q),
      .scale_i       (scale_q),
      .kp_i          (gains_q[47:32]),
      .ki_i          (gains_q[31:16]),
      .kd_i          (gains_q[15:0]),
      .limit_i       (limit_q),
      .count_i       (count_q[w]),
      .power_o       (power[w])
    );
    assign merged[16*w +: 16] = power[w];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= owsp_pkg::StepCommit)
    else $error("lane step out of schedule");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && step_q == owsp_pkg::StepNormSin)
    else $error("accepted tick did not start the lanes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q) == owsp_pkg::StepCommit && !busy_q)
    else $error("result raised outside commit");

endmodule

// ===== dv/tb_omni_wheel_speed_pid.sv =====
// Testbench for the omni wheel speed controller: stream driver, monitor and bit-exact predictor.
module tb_omni_wheel_speed_pid;

  localparam int unsigned NW = 4;
  localparam int unsigned AddrW = $clog2(8*(NW+4));
  localparam int unsigned IdxBodyRadius = NW;
  localparam int unsigned IdxCountScale = NW + 1;
  localparam int unsigned IdxPidGains   = NW + 2;
  localparam int unsigned IdxPowerLimit = NW + 3;
  localparam int unsigned WatchLimit    = 20000;

  typedef struct packed {
    logic                   new_cmd;
    logic [72+16*NW-1:0]    data;
  } tick_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [72+16*NW-1:0]   s_axis_tdata_i;
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [16*NW-1:0]      m_axis_tdata_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AddrW-1:0]      paddr;
  logic [63:0]           pwdata;
  logic [63:0]           prdata;
  logic                  pready;

  omni_wheel_speed_pid #(.NUM_WHEELS(NW)) i_dut (.*);

  // predictor state
  logic [31:0] dir_q [NW];
  logic [15:0] radius_q;
  logic [23:0] scale_q;
  logic [47:0] gains_q;
  logic [14:0] limit_q;
  logic signed [23:0] tgt_tan, tgt_nrm, tgt_ang;
  logic [15:0] prev_cnt [NW];
  logic signed [31:0] prev_err [NW];
  logic signed [15:0] integ [NW];

  tick_t       pending_ticks[$];
  logic [16*NW-1:0] expected_powers[$];
  int          n_errors;
  bit          rx_free_run, tx_free_run;
  int          hold_off;
  bit          in_taken;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_lim(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [16*NW-1:0] compute_powers(tick_t t);
    logic [16*NW-1:0] r;
    longint s, c, acc, target, delta, meas, err, p, d, i, pw, kp, ki, kd, lim;
    logic [15:0] cnt;
    lim = longint'(limit_q);
    kp = longint'(gains_q[47:32]);
    ki = longint'(gains_q[31:16]);
    kd = longint'(gains_q[15:0]);
    if (t.new_cmd) begin
      tgt_tan = t.data[23:0];
      tgt_nrm = t.data[47:24];
      tgt_ang = t.data[71:48];
    end
    for (int w = 0; w < NW; w++) begin
      s = longint'($signed(dir_q[w][31:16]));
      c = longint'($signed(dir_q[w][15:0]));
      acc = 2 * longint'(tgt_nrm) * s + 2 * longint'(tgt_tan) * c
          + longint'(tgt_ang) * longint'(radius_q);
      target = floor_sh(acc, 16);
      cnt = t.data[72+16*w +: 16];
      delta = longint'($signed(cnt - prev_cnt[w]));
      meas = delta * longint'(scale_q);
      prev_cnt[w] = cnt;
      err = target - meas;
      if (err > 64'sd2147483647) err = 64'sd2147483647;
      if (err < -64'sd2147483648) err = -64'sd2147483648;
      p = floor_sh(kp * err, 9);
      d = floor_sh(kd * (err - longint'(prev_err[w])), 9);
      i = clamp_lim(longint'(integ[w]) + floor_sh(ki * err, 9), lim);
      prev_err[w] = err[31:0];
      integ[w] = i[15:0];
      pw = clamp_lim(p + i + d, lim);
      r[16*w +: 16] = pw[15:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_v, $time);
    n_errors++;
  endtask

  task automatic write_reg(int idx, logic [63:0] val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = AddrW'(8 * idx); pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      IdxBodyRadius: radius_q = val[15:0];
      IdxCountScale: scale_q = val[23:0];
      IdxPidGains:   gains_q = val[47:0];
      IdxPowerLimit: limit_q = val[14:0];
      default:       dir_q[idx] = val[31:0];
    endcase
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || expected_powers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd_q15_dir();
    case ($urandom_range(0, 3))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_tick(logic nc, logic [23:0] tn, logic [23:0] nr, logic [23:0] an,
                           logic [63:0] cnts);
    tick_t t;
    t.new_cmd = nc;
    t.data = {cnts, an, nr, tn};
    pending_ticks.push_back(t);
  endtask

  // encoder walk for random ticks: small steps mostly, occasional wild jumps
  logic [15:0] enc_pos [NW];

  task automatic push_random_tick();
    logic [63:0] cnts;
    for (int w = 0; w < NW; w++) begin
      if ($urandom_range(0, 9) == 0) enc_pos[w] = 16'($urandom);
      else enc_pos[w] = enc_pos[w] + 16'($signed(8'($urandom)));
      cnts[16*w +: 16] = enc_pos[w];
    end
    push_tick($urandom_range(0, 3) == 0, 24'($urandom), 24'($urandom), 24'($urandom), cnts);
  endtask

  task automatic random_config(int mode);
    for (int w = 0; w < NW; w++) write_reg(w, 64'({rnd_q15_dir(), rnd_q15_dir()}));
    write_reg(IdxBodyRadius, mode == 0 ? 64'hffff : 64'($urandom_range(0, 65535)));
    write_reg(IdxCountScale, mode == 0 ? 64'hffffff : 64'($urandom_range(0, 4095)));
    write_reg(IdxPidGains, mode == 0 ? 64'hffff_ffff_ffff
                                     : 64'({16'($urandom_range(0, 4095)),
                                            16'($urandom_range(0, 1023)),
                                            16'($urandom_range(0, 255))}));
    write_reg(IdxPowerLimit, mode == 0 ? 64'h7fff : mode == 1 ? 64'd0
                                               : 64'($urandom_range(1, 32767)));
  endtask

  // driver: the queue front is the transaction on the bus until it is accepted
  int tx_gap;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && !in_taken) begin
        // hold
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i <= pending_ticks[0].new_cmd;
        s_axis_tdata_i <= pending_ticks[0].data;
        if (!tx_free_run && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 16);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver ready
  int rx_gap;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!rx_free_run && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 16);
      end
    end
  end

  // monitor and watchdog
  int idle_cycles;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_powers.push_back(compute_powers(pending_ticks.pop_front()));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_powers.size() == 0) begin
          report_mismatch("unexpected result", 64'(m_axis_tdata_o), 64'd0);
        end else begin
          for (int w = 0; w < NW; w++)
            if (m_axis_tdata_o[16*w +: 16] !== expected_powers[0][16*w +: 16])
              report_mismatch($sformatf("motor_power_%0d", w),
                              64'(m_axis_tdata_o[16*w +: 16]),
                              64'(expected_powers[0][16*w +: 16]));
          void'(expected_powers.pop_front());
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0; s_axis_tuser_i = 1'b0; s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    n_errors = 0; tx_gap = 0; rx_gap = 0; hold_off = 0; idle_cycles = 0;
    in_taken = 1'b0;
    rx_free_run = 1'b0; tx_free_run = 1'b0;
    for (int w = 0; w < NW; w++) begin
      dir_q[w] = '0; prev_cnt[w] = '0; prev_err[w] = '0; integ[w] = '0; enc_pos[w] = '0;
    end
    radius_q = '0; scale_q = '0; gains_q = 48'd10995133054976; limit_q = 15'd16384;
    tgt_tan = '0; tgt_nrm = '0; tgt_ang = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults first, then extremes
    push_tick(1'b1, 24'h7fffff, 24'h800000, 24'h7fffff, 64'h0);
    push_tick(1'b0, 24'h123456, 24'h654321, 24'h0, 64'h7fff_8000_0001_ffff);
    drain();
    random_config(0);
    push_tick(1'b1, 24'h7fffff, 24'h7fffff, 24'h7fffff, 64'h0);
    push_tick(1'b1, 24'h800000, 24'h800000, 24'h800000, 64'h8000_8000_8000_8000);
    push_tick(1'b0, 24'hffffff, 24'hffffff, 24'hffffff, 64'h0000_0000_0000_0000);
    push_tick(1'b0, 24'h0, 24'h0, 24'h0, 64'h7fff_7fff_7fff_7fff);
    push_tick(1'b1, 24'h0, 24'h0, 24'h0, 64'hffff_ffff_ffff_ffff);
    push_tick(1'b0, 24'h0, 24'h0, 24'h0, 64'h0000_0000_0000_0000);
    drain();
    // zero limit holds everything at zero
    random_config(1);
    for (int k = 0; k < 6; k++) push_random_tick();
    drain();

    // long receiver stall while the sender keeps offering
    random_config(2);
    hold_off = 300;
    for (int k = 0; k < 40; k++) push_random_tick();
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      random_config(phase == 3 ? 0 : phase == 5 ? 1 : 2);
      if (phase == 7) begin
        rx_free_run = 1'b1; tx_free_run = 1'b1;
      end
      for (int k = 0; k < 220; k++) push_random_tick();
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== omni_wheel_speed_pid.f =====
design/owsp_pkg.sv
design/owsp_lane.sv
design/omni_wheel_speed_pid.sv
dv/tb_omni_wheel_speed_pid.sv
